FILE: sv/sap_pkg.sv
// Shared constants, types and codes of the slab object allocator.
`default_nettype none
package sap_pkg;
	localparam int MAX_SLABS      = 16;
	localparam int MAX_SLOTS      = 512;
	localparam int SLAB_ADDR_BITS = 17;
	localparam int MIN_OBJECT     = 8;
	localparam int PAGE_BYTES     = 4096;
	localparam int BIG_OBJECT     = 1024;
	localparam int ADDR_W         = 21;
	localparam int CMD_W          = 2;
	localparam int STAT_W         = 2;
	localparam int SIZE_W         = 16;
	localparam int SLAB_W         = $clog2(MAX_SLABS);
	localparam int CNT_W          = $clog2(MAX_SLABS + 1);
	localparam int SLOT_W         = $clog2(MAX_SLOTS);
	localparam int LINK_W         = $clog2(MAX_SLOTS + 1);
	localparam int FCNT_W         = 10;
	localparam int FCNT_MAX       = (1 << FCNT_W) - 1;
	localparam int LINK_DEPTH     = MAX_SLABS * MAX_SLOTS;
	localparam int LADDR_W        = SLAB_W + SLOT_W;
	localparam int DIV_W          = SLAB_ADDR_BITS + 1;
	localparam int KEY_W          = ADDR_W - SLAB_ADDR_BITS;
	localparam int SPAN_BYTES     = 1 << SLAB_ADDR_BITS;

	localparam logic [LINK_W-1:0] END_LINK = LINK_W'(MAX_SLOTS);

	localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_OOM    = 2'd1;
	localparam logic [STAT_W-1:0] STAT_BADPTR = 2'd2;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_e;

	typedef enum logic [3:0] {
		S_IDLE,
		S_GEO,
		S_SCAN,
		S_NEW,
		S_FILL,
		S_POPRD,
		S_POPWB,
		S_FDIV,
		S_RES
	} state_t;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [ADDR_W-1:0] address_in;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] address_out;
		logic [STAT_W-1:0] status;
	} rsp_t;

	typedef struct packed {
		logic [CNT_W-1:0] slab_count;
		logic             geo_ok;
	} stat_t;
endpackage
`default_nettype wire

FILE: sv/sap_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sap_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

FILE: sv/sap_front.sv
// Front end: two-entry request queue between the input port and the engine.
`default_nettype none
module sap_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire sap_pkg::req_t request,
	output logic               full,
	input  wire logic          take,
	output logic               head_valid,
	output sap_pkg::req_t      head
);
	sap_pkg::req_t mem_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;
	logic          do_push;
	logic          do_take;

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head       = mem_q[rd_q];
	assign do_push    = push && !full;
	assign do_take    = take && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= request;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_take) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_take);
		end
	end
endmodule
`default_nettype wire

FILE: sv/sap_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module sap_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [sap_pkg::DIV_W-1:0]    dividend,
	input  wire logic [sap_pkg::SIZE_W-1:0]   divisor,
	output logic                              done,
	output logic      [sap_pkg::DIV_W-1:0]    quot,
	output logic      [sap_pkg::SIZE_W-1:0]   rem
);
	localparam int CW = $clog2(sap_pkg::DIV_W);

	logic [sap_pkg::SIZE_W-1:0] rem_q;
	logic [sap_pkg::DIV_W-1:0]  quo_q;
	logic [sap_pkg::SIZE_W-1:0] dvs_q;
	logic [CW-1:0]              cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [sap_pkg::SIZE_W:0]   trial;
	logic                       fits;
	logic [sap_pkg::SIZE_W:0]   diff;

	assign trial = {rem_q, quo_q[sap_pkg::DIV_W-1]};
	assign fits  = (trial >= {1'b0, dvs_q});
	assign diff  = trial - {1'b0, dvs_q};
	assign done  = done_q;
	assign quot  = quo_q;
	assign rem   = rem_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[sap_pkg::SIZE_W-1:0] : trial[sap_pkg::SIZE_W-1:0];
			quo_q <= {quo_q[sap_pkg::DIV_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(sap_pkg::DIV_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

FILE: sv/sap_back.sv
// Back end: slab bookkeeping, free-list engine and result register.
`default_nettype none
module sap_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [sap_pkg::SIZE_W-1:0]   cfg_data,
	input  wire logic                         head_valid,
	input  wire sap_pkg::req_t                head,
	output logic                              take,
	output logic                              empty,
	input  wire logic                         pop,
	output sap_pkg::rsp_t                     result,
	output sap_pkg::stat_t                    stat
);
	sap_pkg::state_t state_q, state_d;

	logic [sap_pkg::SIZE_W-1:0] size_q;
	logic                       geo_ok_q;
	logic [sap_pkg::LINK_W-1:0] slots_q;
	logic [sap_pkg::CNT_W-1:0]  slab_cnt_q;
	logic [sap_pkg::FCNT_W-1:0] fcount_q [sap_pkg::MAX_SLABS];
	logic [sap_pkg::LINK_W-1:0] fhead_q  [sap_pkg::MAX_SLABS];
	logic [sap_pkg::SLAB_W-1:0] idx_q;
	logic [sap_pkg::SLAB_W-1:0] found_q;
	logic [sap_pkg::LINK_W-1:0] fill_q;
	logic [sap_pkg::SLOT_W-1:0] slot_q;
	sap_pkg::req_t              item_q;
	sap_pkg::rsp_t              res_q;
	sap_pkg::rsp_t              out_q;
	logic                       out_valid_q;

	logic [sap_pkg::SIZE_W-1:0] eff;
	logic [31:0]                bytes_raw;
	logic [31:0]                bytes_cap;
	logic                       div_start;
	logic [sap_pkg::DIV_W-1:0]  div_dividend;
	logic                       div_done;
	logic [sap_pkg::DIV_W-1:0]  div_quot;
	logic [sap_pkg::SIZE_W-1:0] div_rem;
	logic                       hit;
	logic                       out_free;
	logic [sap_pkg::KEY_W-1:0]  key;
	logic [sap_pkg::SLAB_W-1:0] kslab;
	logic                       bad;
	logic [sap_pkg::LINK_W-1:0] fill_nx;
	logic                       fill_last;
	logic                       no_room;
	logic [sap_pkg::ADDR_W-1:0] alloc_addr;
	logic                       lk_we;
	logic [sap_pkg::LADDR_W-1:0] lk_waddr;
	logic [sap_pkg::LINK_W-1:0] lk_wdata;
	logic [sap_pkg::LADDR_W-1:0] lk_raddr;
	logic [sap_pkg::LINK_W-1:0] lk_rdata;

	assign eff = (size_q < sap_pkg::SIZE_W'(sap_pkg::MIN_OBJECT))
		? sap_pkg::SIZE_W'(sap_pkg::MIN_OBJECT) : size_q;
	assign bytes_raw = (size_q > sap_pkg::SIZE_W'(sap_pkg::BIG_OBJECT))
		? ((32'(size_q) >> 12) + 32'd1) << 12 : 32'(sap_pkg::PAGE_BYTES);
	assign bytes_cap = (bytes_raw > 32'(sap_pkg::SPAN_BYTES))
		? 32'(sap_pkg::SPAN_BYTES) : bytes_raw;

	assign key   = item_q.address_in[sap_pkg::ADDR_W-1:sap_pkg::SLAB_ADDR_BITS];
	assign kslab = sap_pkg::SLAB_W'(key);
	assign bad   = (32'(key) >= 32'(slab_cnt_q)) || (div_rem != '0)
		|| (32'(div_quot) >= 32'(slots_q));
	assign hit   = (fcount_q[idx_q] != '0) && (fhead_q[idx_q] < slots_q);
	assign fill_nx   = fill_q + 1'b1;
	assign fill_last = (fill_nx >= slots_q);
	assign no_room   = (32'(slab_cnt_q) >= 32'(sap_pkg::MAX_SLABS)) || (slots_q == '0);
	assign alloc_addr = (sap_pkg::ADDR_W'(found_q) << sap_pkg::SLAB_ADDR_BITS)
		+ sap_pkg::ADDR_W'(slot_q * eff);
	assign out_free = !out_valid_q || pop;
	assign empty    = !out_valid_q;
	assign result   = out_q;
	assign stat     = '{slab_count: slab_cnt_q, geo_ok: geo_ok_q};

	sap_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (eff),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	sap_ram #(
		.WIDTH (sap_pkg::LINK_W),
		.DEPTH (sap_pkg::LINK_DEPTH)
	) u_link (
		.clk   (clk),
		.we    (lk_we),
		.waddr (lk_waddr),
		.wdata (lk_wdata),
		.raddr (lk_raddr),
		.rdata (lk_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			sap_pkg::S_IDLE: begin
				if (!geo_ok_q) begin
					state_d = sap_pkg::S_GEO;
				end else if (head_valid) begin
					case (head.command)
						sap_pkg::CMD_ALLOC: state_d = (slab_cnt_q == '0)
							? sap_pkg::S_NEW : sap_pkg::S_SCAN;
						sap_pkg::CMD_FREE:  state_d = sap_pkg::S_FDIV;
						default:            state_d = sap_pkg::S_RES;
					endcase
				end
			end
			sap_pkg::S_GEO: begin
				if (div_done) begin
					state_d = sap_pkg::S_IDLE;
				end
			end
			sap_pkg::S_SCAN: begin
				if (hit) begin
					state_d = sap_pkg::S_POPRD;
				end else if (idx_q == '0) begin
					state_d = sap_pkg::S_NEW;
				end
			end
			sap_pkg::S_NEW: state_d = no_room ? sap_pkg::S_RES : sap_pkg::S_FILL;
			sap_pkg::S_FILL: begin
				if (fill_last) begin
					state_d = sap_pkg::S_POPRD;
				end
			end
			sap_pkg::S_POPRD: state_d = sap_pkg::S_POPWB;
			sap_pkg::S_POPWB: state_d = sap_pkg::S_RES;
			sap_pkg::S_FDIV: begin
				if (div_done) begin
					state_d = sap_pkg::S_RES;
				end
			end
			sap_pkg::S_RES: begin
				if (out_free) begin
					state_d = sap_pkg::S_IDLE;
				end
			end
			default: state_d = sap_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		take         = 1'b0;
		div_start    = 1'b0;
		div_dividend = sap_pkg::DIV_W'(bytes_cap);
		lk_we        = 1'b0;
		lk_waddr     = {found_q, fill_q[sap_pkg::SLOT_W-1:0]};
		lk_wdata     = fill_last ? sap_pkg::END_LINK : fill_nx;
		lk_raddr     = {found_q, fhead_q[found_q][sap_pkg::SLOT_W-1:0]};
		case (state_q)
			sap_pkg::S_IDLE: begin
				if (!geo_ok_q) begin
					div_start = 1'b1;
				end else if (head_valid) begin
					take         = 1'b1;
					div_start    = (head.command == sap_pkg::CMD_FREE);
					div_dividend = sap_pkg::DIV_W'(
						head.address_in[sap_pkg::SLAB_ADDR_BITS-1:0]);
				end
			end
			sap_pkg::S_FILL: lk_we = 1'b1;
			sap_pkg::S_FDIV: begin
				lk_we    = div_done && !bad;
				lk_waddr = {kslab, div_quot[sap_pkg::SLOT_W-1:0]};
				lk_wdata = fhead_q[kslab];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			sap_pkg::S_IDLE: begin
				item_q <= head;
				res_q  <= '{address_out: '0, status: sap_pkg::STAT_OK};
				idx_q  <= sap_pkg::SLAB_W'(slab_cnt_q - 1'b1);
			end
			sap_pkg::S_SCAN: begin
				found_q <= idx_q;
				idx_q   <= idx_q - 1'b1;
			end
			sap_pkg::S_NEW: begin
				found_q <= sap_pkg::SLAB_W'(slab_cnt_q);
				fill_q  <= '0;
				res_q   <= '{address_out: '0, status: sap_pkg::STAT_OOM};
			end
			sap_pkg::S_FILL: begin
				fill_q <= fill_nx;
				if (fill_last) begin
					fcount_q[found_q] <= sap_pkg::FCNT_W'(slots_q);
					fhead_q[found_q]  <= '0;
				end
			end
			sap_pkg::S_POPRD: slot_q <= fhead_q[found_q][sap_pkg::SLOT_W-1:0];
			sap_pkg::S_POPWB: begin
				fhead_q[found_q]  <= lk_rdata;
				fcount_q[found_q] <= fcount_q[found_q] - 1'b1;
				res_q <= '{address_out: alloc_addr, status: sap_pkg::STAT_OK};
			end
			sap_pkg::S_FDIV: begin
				if (div_done) begin
					if (bad) begin
						res_q <= '{address_out: '0, status: sap_pkg::STAT_BADPTR};
					end else begin
						fhead_q[kslab] <= sap_pkg::LINK_W'(div_quot);
						if (fcount_q[kslab] != sap_pkg::FCNT_W'(sap_pkg::FCNT_MAX)) begin
							fcount_q[kslab] <= fcount_q[kslab] + 1'b1;
						end
					end
				end
			end
			default: begin
			end
		endcase
		if (state_q == sap_pkg::S_RES && out_free) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sap_pkg::S_IDLE;
			size_q      <= sap_pkg::SIZE_W'(sap_pkg::MIN_OBJECT);
			geo_ok_q    <= 1'b0;
			slots_q     <= '0;
			slab_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == sap_pkg::S_GEO && div_done) begin
				geo_ok_q <= 1'b1;
				slots_q  <= (32'(div_quot) > 32'(sap_pkg::MAX_SLOTS))
					? sap_pkg::END_LINK : sap_pkg::LINK_W'(div_quot);
			end
			if (cfg_we) begin
				size_q     <= cfg_data;
				geo_ok_q   <= 1'b0;
				slab_cnt_q <= '0;
			end else if (state_q == sap_pkg::S_FILL && fill_last) begin
				slab_cnt_q <= slab_cnt_q + 1'b1;
			end else if (state_q == sap_pkg::S_IDLE && geo_ok_q && head_valid
				&& head.command == sap_pkg::CMD_CLEAR) begin
				slab_cnt_q <= '0;
			end
			if (state_q == sap_pkg::S_RES && out_free) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

FILE: sv/slab_object_allocator_top.sv
// Top level of the slab object allocator: request queue, engine, result port.
//
// A clear or an unused command goes straight from the idle state to the result state. An
// alloc walks the slabs newest first at one slab a cycle; creating a slab writes its slot
// links one per cycle into the link memory, one link per slot (up to 512 slots).
// A free runs the offset through the 18-bit restoring divider before its result is made.
// After reset and after every object_size write the slot count is recomputed by the
// same divider, and no request is started until it is done. Requests queue two
// deep in front of the engine and one result waits in the output register.
`default_nettype none
module slab_object_allocator_top (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire sap_pkg::req_t              request,
	output logic                            full,
	output logic                            empty,
	input  wire logic                       pop,
	output sap_pkg::rsp_t                   result,
	input  wire logic                       cfg_we,
	input  wire logic [sap_pkg::SIZE_W-1:0] cfg_data
);
	logic           head_valid;
	sap_pkg::req_t  head;
	logic           take;
	sap_pkg::stat_t stat;

	sap_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.request    (request),
		.full       (full),
		.take       (take),
		.head_valid (head_valid),
		.head       (head)
	);

	sap_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.head_valid (head_valid),
		.head       (head),
		.take       (take),
		.empty      (empty),
		.pop        (pop),
		.result     (result),
		.stat       (stat)
	);

	a_slab_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(stat.slab_count) <= sap_pkg::MAX_SLABS)
		else $error("slab count beyond pool");

	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (stat.slab_count == '0) && !stat.geo_ok)
		else $error("size write did not empty the pool");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.status == sap_pkg::STAT_OK
			|| result.status == sap_pkg::STAT_OOM
			|| result.status == sap_pkg::STAT_BADPTR))
		else $error("bad status code");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status != sap_pkg::STAT_OK) |-> (result.address_out == '0))
		else $error("failed beat carries an address");
endmodule
`default_nettype wire
